FILE: hdl/double_ended_queue_macros.svh
// Assertion macros used by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DEQ_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DEQ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic search_step;
    logic search_hit;
    logic search_miss;
    logic shift_step;
    logic shift_done;
    logic load_out;
  } deq_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic match;
    logic shift_end;
  } deq_stat_t;

endpackage

FILE: hdl/deq_ctrl.sv
// Request sequencer and output handshake for the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  deq_stat_t         stat,
  output deq_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   can_accept;
  state_t start_state;

  assign out_free    = !out_valid_r || !out_stall;
  assign can_accept  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_free);
  assign in_stall    = !can_accept;
  assign out_valid   = out_valid_r;
  assign start_state = (in_func == FUNC_REMOVE) ? S_SEARCH : S_EXEC;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cmd.accept = in_valid && can_accept;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = start_state;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_SEARCH: begin
        if (stat.scan_end) begin
          cmd.search_miss = 1'b1;
          state_nxt       = S_RESP;
        end else if (stat.match) begin
          cmd.search_hit = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          cmd.shift_done = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = cmd.accept ? start_state : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/deq_dp.sv
// Ring storage, pointers and result registers of the double-ended queue.
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic                in_end_sel,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [INDEX_W-1:0]  in_index,
  input  deq_cmd_t            cmd,
  output deq_stat_t           stat,
  output logic [VALUE_W-1:0]  out_read_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int SW = OW + 1;
  localparam int CW = (OW > INDEX_W) ? OW : INDEX_W;

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]         head_r;
  logic [OW-1:0]         occ_r;
  func_t                 req_func_r;
  logic                  req_tail_r;
  logic [DATA_WIDTH-1:0] req_key_r;
  logic [INDEX_W-1:0]    req_index_r;
  logic [OW-1:0]         cmp_i_r;
  logic [OW-1:0]         sh_r;
  logic [DATA_WIDTH-1:0] res_value_r;
  status_t               res_status_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [OW-1:0]         in_i;
  logic [OW-1:0]         hit_k;
  logic [OW-1:0]         rd_k;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;
  logic                  is_full;
  logic                  is_empty;
  logic                  out_of_range;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd, input logic [OW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(hd) + SW'(k);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return AW'(sum);
  endfunction

  function automatic logic [OW-1:0] logical_pos(input logic tl, input logic [OW-1:0] i,
                                                input logic [OW-1:0] occ);
    return tl ? (occ - OW'(1) - i) : i;
  endfunction

  assign is_full      = (occ_r == OW'(DEPTH));
  assign is_empty     = (occ_r == '0);
  assign out_of_range = (CW'(req_index_r) >= CW'(occ_r));
  assign head_dec     = (head_r == '0) ? AW'(DEPTH - 1) : (head_r - AW'(1));
  assign head_inc     = (head_r == AW'(DEPTH - 1)) ? '0 : (head_r + AW'(1));
  assign in_i         = (in_func == FUNC_PEEK) ? OW'(in_index) : '0;
  assign hit_k        = logical_pos(req_tail_r, cmp_i_r, occ_r);

  always_comb begin
    if (cmd.accept) begin
      rd_k = logical_pos(in_end_sel, in_i, occ_r);
    end else if (cmd.search_hit) begin
      rd_k = hit_k + OW'(1);
    end else if (cmd.shift_step) begin
      rd_k = sh_r + OW'(2);
    end else begin
      rd_k = logical_pos(req_tail_r, cmp_i_r + OW'(1), occ_r);
    end
  end

  assign rd_addr = slot_of(head_r, rd_k);
  assign wr_en   = (cmd.exec && (req_func_r == FUNC_PUT) && !is_full) || cmd.shift_step;
  assign wr_data = cmd.shift_step ? rd_data_r : req_key_r;

  always_comb begin
    if (cmd.shift_step) begin
      wr_addr = slot_of(head_r, sh_r);
    end else if (req_tail_r) begin
      wr_addr = slot_of(head_r, occ_r);
    end else begin
      wr_addr = head_dec;
    end
  end

  assign stat.scan_end  = (cmp_i_r >= occ_r);
  assign stat.match     = (rd_data_r == req_key_r);
  assign stat.shift_end = ((SW'(sh_r) + SW'(1)) >= SW'(occ_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else if (cmd.exec) begin
      unique case (req_func_r)
        FUNC_PUT: begin
          if (!is_full) begin
            if (!req_tail_r) begin
              head_r <= head_dec;
            end
            occ_r <= occ_r + OW'(1);
          end
        end
        FUNC_GET: begin
          if (!is_empty) begin
            if (!req_tail_r) begin
              head_r <= head_inc;
            end
            occ_r <= occ_r - OW'(1);
          end
        end
        FUNC_PEEK, FUNC_REMOVE: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.shift_done) begin
      occ_r <= occ_r - OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func_r  <= func_t'(in_func);
      req_tail_r  <= in_end_sel;
      req_key_r   <= DATA_WIDTH'(in_value);
      req_index_r <= in_index;
      cmp_i_r     <= '0;
    end else if (cmd.search_step) begin
      cmp_i_r <= cmp_i_r + OW'(1);
    end

    if (cmd.search_hit) begin
      sh_r <= hit_k;
    end else if (cmd.shift_step) begin
      sh_r <= sh_r + OW'(1);
    end

    if (cmd.exec) begin
      res_value_r  <= '0;
      res_status_r <= ST_OK;
      unique case (req_func_r)
        FUNC_PUT: begin
          if (is_full) begin
            res_status_r <= ST_FULL;
          end
        end
        FUNC_GET: begin
          if (is_empty) begin
            res_status_r <= ST_EMPTY;
          end else begin
            res_value_r <= rd_data_r;
          end
        end
        FUNC_PEEK: begin
          if (out_of_range) begin
            res_status_r <= ST_RANGE;
          end else begin
            res_value_r <= rd_data_r;
          end
        end
        FUNC_REMOVE: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.search_miss) begin
      res_value_r  <= '0;
      res_status_r <= ST_NOTFOUND;
    end else if (cmd.search_hit) begin
      res_value_r  <= rd_data_r;
      res_status_r <= ST_OK;
    end

    if (cmd.load_out) begin
      out_value_r  <= VALUE_W'(res_value_r);
      out_status_r <= res_status_r;
      out_count_r  <= COUNT_W'(occ_r);
    end
  end

  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

FILE: hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
// Input channel: in_valid, in_stall, and one request of in_func, in_end_sel, in_value,
// in_index. A request is taken on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid, out_stall, and out_read_value, out_status, out_count.
// Every request produces exactly one result, in request order.
// Put, get and peek: the request is registered, then executed, then its result is loaded
// into the output register and shows on out_valid; the next request can be taken in the
// same cycle as that result is loaded.
// Remove by value: held words are compared until a match (all held words on a miss),
// then the words after the match are moved to close the gap, then the result is loaded;
// the ring is read and written one word per cycle.
// A result waits in the output register while out_stall is high; one further request
// is taken and worked on meanwhile, and the block then holds in_stall high until the
// output register frees.
// Reset (rst_n low at a clock edge) empties the queue and drops any pending result;
// stored words are not cleared.
`timescale 1ns / 1ps

module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic                in_end_sel,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [INDEX_W-1:0]  in_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VALUE_W-1:0]  out_read_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_end_sel     (in_end_sel),
    .in_value       (in_value),
    .in_index       (in_index),
    .cmd            (cmd),
    .stat           (stat),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

endmodule

FILE: hdl/deq_checker.sv
// Port-level checks of the double-ended queue results, bound to the top level.
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_checker import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [VALUE_W-1:0]  out_read_value,
  input logic [STATUS_W-1:0] out_status,
  input logic [COUNT_W-1:0]  out_count
);

  logic               out_acc;
  logic [COUNT_W-1:0] prev_count_r;
  logic [COUNT_W-1:0] count_up;
  logic [COUNT_W-1:0] count_down;

  assign out_acc    = out_valid && !out_stall;
  assign count_up   = prev_count_r + COUNT_W'(1);
  assign count_down = prev_count_r - COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
    end else if (out_acc) begin
      prev_count_r <= out_count;
    end
  end

  `DEQ_CHECK_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_count), "Stalled result changed.")
  `DEQ_CHECK_NOW(a_fail_keeps_count, out_acc && (out_status != ST_OK), out_count == prev_count_r, "Failed request changed the count.")
  `DEQ_CHECK_NOW(a_count_step, out_acc && (out_status == ST_OK), (out_count == prev_count_r) || (out_count == count_up) || (out_count == count_down), "Count moved by more than one word.")
  `DEQ_CHECK_NOW(a_full_count, out_valid && (out_status == ST_FULL), out_count == COUNT_W'(DEPTH), "Full status with a count below the depth.")
  `DEQ_CHECK_NOW(a_fail_zero, out_valid && (out_status != ST_OK), out_read_value == '0, "Failed request returned a nonzero word.")

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);
